[design/olist_pkg.sv]
// Shared types and constants for the ordered list engine.
// No dependencies; used by olist_ctrl, olist_dp and ordered_list_engine_top.
`timescale 1ns / 1ps

package olist_pkg;

  localparam int unsigned CAPACITY = 16;

  typedef enum logic [2:0] {
    CMD_INSERT  = 3'd0,
    CMD_REMOVE  = 3'd1,
    CMD_FIND    = 3'd2,
    CMD_REVERSE = 3'd3,
    CMD_CLEAR   = 3'd4,
    CMD_READ    = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  // write data source for the list memory
  typedef enum logic [1:0] {
    WSEL_VALUE = 2'd0,
    WSEL_RDATA = 2'd1,
    WSEL_HOLD  = 2'd2
  } wsel_e;

  typedef struct packed {
    logic [2:0]         command;
    logic [4:0]         position;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         found_position;
    logic signed [31:0] read_value;
    logic [4:0]         entry_count;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic    in_load;
    logic    rd_en;
    logic    wr_en;
    wsel_e   wr_sel;
    logic    hold_en;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    cnt_clr;
    logic    res_load;
    status_e res_status;
    logic [3:0] res_fpos;
    logic    res_rv_en;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] command;
    logic [4:0] position;
    logic       match;
    logic       out_full;
  } dp_sts_t;

endpackage

[design/olist_dp.sv]
// Datapath: list memory, entry count, latched command beat and result register.
// Depends on olist_pkg; driven by olist_ctrl.
`timescale 1ns / 1ps

module olist_dp #(
  parameter int unsigned Capacity = olist_pkg::CAPACITY,
  localparam int unsigned AW = (Capacity > 1) ? $clog2(Capacity) : 1,
  localparam int unsigned CW = $clog2(Capacity + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  olist_pkg::in_t      in_data_i,
  input  olist_pkg::ctrl_cmd_t cmd_i,
  input  logic [AW-1:0]       rd_addr_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  logic                out_stall_i,
  output olist_pkg::dp_sts_t  sts_o,
  output logic [CW-1:0]       count_o,
  output logic                out_valid_o,
  output olist_pkg::out_t     out_data_o
);

  logic signed [31:0] mem_q [Capacity];
  logic signed [31:0] rdata_q;
  logic signed [31:0] hold_q;
  logic signed [31:0] wdata;
  olist_pkg::in_t     beat_q;
  logic [CW-1:0]      count_q, count_d;
  logic               out_valid_q, out_valid_d;
  olist_pkg::out_t    out_q;

  always_comb begin
    case (cmd_i.wr_sel)
      olist_pkg::WSEL_RDATA: wdata = rdata_q;
      olist_pkg::WSEL_HOLD:  wdata = hold_q;
      default:               wdata = beat_q.value;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr_i] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr_i];
    end
    if (cmd_i.hold_en) begin
      hold_q <= rdata_q;
    end
    if (cmd_i.in_load) begin
      beat_q <= in_data_i;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_clr) begin
      count_d = '0;
    end else if (cmd_i.cnt_inc) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.res_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_q.status         <= cmd_i.res_status;
      out_q.found_position <= cmd_i.res_fpos;
      out_q.read_value     <= cmd_i.res_rv_en ? rdata_q : 32'sd0;
      out_q.entry_count    <= 5'(count_q);
    end
  end

  assign sts_o.command  = beat_q.command;
  assign sts_o.position = beat_q.position;
  assign sts_o.match    = (rdata_q == beat_q.value);
  assign sts_o.out_full = out_valid_q && out_stall_i;

  assign count_o     = count_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_cnt_inc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc && !cmd_i.cnt_clr |=> count_q == CW'($past(count_q) + 1'b1))
    else $error("count did not step up");

  a_cnt_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.cnt_inc && !cmd_i.cnt_dec && !cmd_i.cnt_clr |=> $stable(count_q))
    else $error("count moved without an update");

  a_cnt_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |-> count_q < CW'(Capacity))
    else $error("insert into a full list");

endmodule

[design/olist_ctrl.sv]
// Controller: sequences each command over the list memory in olist_dp.
// Depends on olist_pkg.
`timescale 1ns / 1ps

module olist_ctrl #(
  parameter int unsigned Capacity = olist_pkg::CAPACITY,
  localparam int unsigned AW = (Capacity > 1) ? $clog2(Capacity) : 1,
  localparam int unsigned CW = $clog2(Capacity + 1),
  localparam int unsigned PW = ((CW > 5) ? CW : 5) + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  olist_pkg::dp_sts_t   sts_i,
  input  logic [CW-1:0]        count_i,
  output olist_pkg::ctrl_cmd_t cmd_o,
  output logic [AW-1:0]        rd_addr_o,
  output logic [AW-1:0]        wr_addr_o
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_DECODE   = 10'b00_0000_0010,
    S_COPY     = 10'b00_0000_0100,
    S_INS_PUT  = 10'b00_0000_1000,
    S_REM_FIN  = 10'b00_0001_0000,
    S_FIND     = 10'b00_0010_0000,
    S_REV_RDLO = 10'b00_0100_0000,
    S_REV_RDHI = 10'b00_1000_0000,
    S_REV_WRLO = 10'b01_0000_0000,
    S_REV_WRHI = 10'b10_0000_0000
  } state_e;

  // done flag: command finished, result waits to be loaded into the output register
  state_e             state_q, state_d;
  logic               done_q, done_d;
  logic [CW-1:0]      c_q, c_d;          // walking cursor, low end for reverse
  logic [CW-1:0]      end_q, end_d;      // last cursor value, high end for reverse
  logic               down_q, down_d;    // copy walks downwards (insert)
  logic               more_q, more_d;    // reads still to issue in a copy walk
  logic               pend_q, pend_d;    // a read is in flight
  logic [CW-1:0]      pend_addr_q, pend_addr_d;
  olist_pkg::status_e st_q, st_d;
  logic [3:0]         fpos_q, fpos_d;
  logic               rv_en_q, rv_en_d;

  logic [PW-1:0] pos_x, cnt_x;

  assign pos_x = PW'(sts_i.position);
  assign cnt_x = PW'(count_i);

  always_comb begin
    state_d     = state_q;
    done_d      = done_q;
    c_d         = c_q;
    end_d       = end_q;
    down_d      = down_q;
    more_d      = more_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    st_d        = st_q;
    fpos_d      = fpos_q;
    rv_en_d     = rv_en_q;

    cmd_o            = '0;
    cmd_o.wr_sel     = olist_pkg::WSEL_VALUE;
    cmd_o.res_status = st_q;
    cmd_o.res_fpos   = fpos_q;
    cmd_o.res_rv_en  = rv_en_q;
    rd_addr_o        = c_q[AW-1:0];
    wr_addr_o        = c_q[AW-1:0];

    if (done_q) begin
      // result waits for the output register
      if (!sts_i.out_full) begin
        cmd_o.res_load = 1'b1;
        done_d         = 1'b0;
        state_d        = S_IDLE;
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_o.in_load = 1'b1;
            state_d       = S_DECODE;
          end
        end

        S_DECODE: begin
          st_d    = olist_pkg::ST_OK;
          fpos_d  = '0;
          rv_en_d = 1'b0;
          pend_d  = 1'b0;
          done_d  = 1'b1;
          unique case (sts_i.command)
            olist_pkg::CMD_INSERT: begin
              if (pos_x > cnt_x) begin
                st_d = olist_pkg::ST_RANGE;
              end else if (cnt_x >= PW'(Capacity)) begin
                st_d = olist_pkg::ST_FULL;
              end else if (pos_x == cnt_x) begin
                done_d  = 1'b0;
                state_d = S_INS_PUT;
              end else begin
                c_d     = count_i - 1'b1;
                end_d   = CW'(sts_i.position);
                down_d  = 1'b1;
                more_d  = 1'b1;
                done_d  = 1'b0;
                state_d = S_COPY;
              end
            end
            olist_pkg::CMD_REMOVE: begin
              if (pos_x >= cnt_x) begin
                st_d = olist_pkg::ST_RANGE;
              end else if (pos_x + 1'b1 < cnt_x) begin
                c_d     = CW'(sts_i.position) + 1'b1;
                end_d   = count_i - 1'b1;
                down_d  = 1'b0;
                more_d  = 1'b1;
                done_d  = 1'b0;
                state_d = S_COPY;
              end else begin
                done_d  = 1'b0;
                state_d = S_REM_FIN;
              end
            end
            olist_pkg::CMD_FIND: begin
              if (count_i == '0) begin
                st_d = olist_pkg::ST_MISSING;
              end else begin
                c_d     = '0;
                done_d  = 1'b0;
                state_d = S_FIND;
              end
            end
            olist_pkg::CMD_REVERSE: begin
              if (cnt_x > PW'(1)) begin
                c_d     = '0;
                end_d   = count_i - 1'b1;
                done_d  = 1'b0;
                state_d = S_REV_RDLO;
              end
            end
            olist_pkg::CMD_CLEAR: begin
              cmd_o.cnt_clr = 1'b1;
            end
            olist_pkg::CMD_READ: begin
              if (pos_x >= cnt_x) begin
                st_d = olist_pkg::ST_RANGE;
              end else begin
                // data lands in rdata and stays there until the result is taken
                cmd_o.rd_en = 1'b1;
                rd_addr_o   = AW'(sts_i.position);
                rv_en_d     = 1'b1;
              end
            end
            default: ;
          endcase
        end

        // shift walk: read one entry a cycle, write it one place over in the cycle after its read
        S_COPY: begin
          if (pend_q) begin
            cmd_o.wr_en  = 1'b1;
            cmd_o.wr_sel = olist_pkg::WSEL_RDATA;
            wr_addr_o    = pend_addr_q[AW-1:0];
          end
          if (more_q) begin
            cmd_o.rd_en = 1'b1;
            rd_addr_o   = c_q[AW-1:0];
            pend_d      = 1'b1;
            pend_addr_d = down_q ? c_q + 1'b1 : c_q - 1'b1;
            if (c_q == end_q) begin
              more_d = 1'b0;
            end else begin
              c_d = down_q ? c_q - 1'b1 : c_q + 1'b1;
            end
          end else begin
            pend_d  = 1'b0;
            state_d = down_q ? S_INS_PUT : S_REM_FIN;
          end
        end

        S_INS_PUT: begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_sel  = olist_pkg::WSEL_VALUE;
          wr_addr_o     = AW'(sts_i.position);
          cmd_o.cnt_inc = 1'b1;
          done_d        = 1'b1;
        end

        S_REM_FIN: begin
          cmd_o.cnt_dec = 1'b1;
          done_d        = 1'b1;
        end

        S_FIND: begin
          if (pend_q && sts_i.match) begin
            fpos_d = 4'(pend_addr_q);
            done_d = 1'b1;
          end else if (c_q < count_i) begin
            cmd_o.rd_en = 1'b1;
            rd_addr_o   = c_q[AW-1:0];
            pend_d      = 1'b1;
            pend_addr_d = c_q;
            c_d         = c_q + 1'b1;
          end else begin
            st_d   = olist_pkg::ST_MISSING;
            done_d = 1'b1;
          end
        end

        S_REV_RDLO: begin
          cmd_o.rd_en = 1'b1;
          rd_addr_o   = c_q[AW-1:0];
          state_d     = S_REV_RDHI;
        end

        S_REV_RDHI: begin
          cmd_o.rd_en   = 1'b1;
          rd_addr_o     = end_q[AW-1:0];
          cmd_o.hold_en = 1'b1;
          state_d       = S_REV_WRLO;
        end

        S_REV_WRLO: begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = olist_pkg::WSEL_RDATA;
          wr_addr_o    = c_q[AW-1:0];
          state_d      = S_REV_WRHI;
        end

        S_REV_WRHI: begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = olist_pkg::WSEL_HOLD;
          wr_addr_o    = end_q[AW-1:0];
          if (PW'(c_q) + PW'(2) < PW'(end_q)) begin
            c_d     = c_q + 1'b1;
            end_d   = end_q - 1'b1;
            state_d = S_REV_RDLO;
          end else begin
            done_d = 1'b1;
          end
        end

        default: state_d = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      pend_q  <= 1'b0;
      more_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      pend_q  <= pend_d;
      more_q  <= more_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q         <= c_d;
    end_q       <= end_d;
    down_q      <= down_d;
    pend_addr_q <= pend_addr_d;
    st_q        <= st_d;
    fpos_q      <= fpos_d;
    rv_en_q     <= rv_en_d;
  end

  assign in_stall_o = (state_q != S_IDLE) || done_q;

  a_res_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |-> !sts_i.out_full)
    else $error("result loaded over a waiting beat");

  a_accept_decode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.in_load |=> state_q == S_DECODE && !done_q)
    else $error("accepted beat not decoded");

  a_port_clash : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en && cmd_o.wr_en |-> rd_addr_o != wr_addr_o)
    else $error("read and write hit the same entry");

endmodule

[design/ordered_list_engine_top.sv]
// Insert and remove shift the tail of the list one place over, find scans up from
// entry zero until a match, and reverse swaps pairs from both ends inwards through
// its read-low, read-high, write-low and write-high states; the shift and the scan
// walk the list memory one entry a cycle.
// One command is in work at a time; the next beat is taken once its result is queued.
// Reset clears the entry count and handshake state; list contents stay undefined.
`timescale 1ns / 1ps

module ordered_list_engine_top #(
  parameter int unsigned Capacity = olist_pkg::CAPACITY
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  olist_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output olist_pkg::out_t out_data_o
);

  localparam int unsigned AW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CW = $clog2(Capacity + 1);

  olist_pkg::ctrl_cmd_t cmd;
  olist_pkg::dp_sts_t   sts;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic [CW-1:0]        count;

  olist_ctrl #(
    .Capacity(Capacity)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .count_i   (count),
    .cmd_o     (cmd),
    .rd_addr_o (rd_addr),
    .wr_addr_o (wr_addr)
  );

  olist_dp #(
    .Capacity(Capacity)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (wr_addr),
    .out_stall_i(out_stall_i),
    .sts_o      (sts),
    .count_o    (count),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o)
  );

endmodule
